### design/mciir_pkg.sv
// shared types, constants and register indexes of the multichannel iir filter
// no dependencies; imported by the top level, the front end and the back end
`default_nettype none

package mciir_pkg;

	// channel count and filter order; the channel field is two bits wide
	localparam int CHANNELS = 4;
	localparam int TAPS     = 4;
	localparam int HIST     = TAPS - 1;
	localparam int HDEPTH   = (HIST > 0) ? HIST : 1;
	localparam int HIDX_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

	// one multiply-accumulate per coefficient in use
	localparam int NSTEPS   = 2 * TAPS - 1;
	localparam int STEP_W   = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int CIDX_W   = 2;

	// exact sum of seven 16x16 products, and its magnitude
	localparam int ACC_W    = 35;
	localparam int MAG_W    = 34;

	// quotient bits formed by the serial divider
	localparam int QBITS    = 16;
	localparam int ITER_W   = $clog2(QBITS);
	localparam int PART_W   = 17;

	// request queue between front and back
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd7;

	typedef logic [1:0]         chan_t;
	typedef logic signed [15:0] sample_t;

	typedef struct packed {
		chan_t   chan;
		sample_t sample;
		logic    in_range;
	} item_t;

	typedef struct packed {
		logic [3:0][15:0] b;
		logic [3:1][15:0] a;
		logic [14:0]      a0;
	} coef_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage

`default_nettype wire

### design/multichannel_iir_filter.sv
// a sample takes seven passes through the one shared multiplier, a setup
// step and sixteen restoring steps of the one-bit divider, which are
// skipped when the quotient magnitude reaches 65536 or coef_a0 is zero;
// the next sample leaves the queue only once this result is registered
// reset: asynchronous, clears the queue, the channel histories and the
// coefficients to b0 = a0 = 1.0, all others zero
`default_nettype none

module multichannel_iir_filter import mciir_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  chan_t                 channel,
	input  sample_t               sample_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output chan_t                 channel_out,
	output sample_t               sample_out,
	output logic                  saturated,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	coef_t coef_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b  <= {16'h0000, 16'h0000, 16'h0000, 16'h4000};
			coef_q.a  <= '0;
			coef_q.a0 <= 15'h4000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:  coef_q.b[0] <= cfg_data;
				REG_B1:  coef_q.b[1] <= cfg_data;
				REG_B2:  coef_q.b[2] <= cfg_data;
				REG_B3:  coef_q.b[3] <= cfg_data;
				REG_A1:  coef_q.a[1] <= cfg_data;
				REG_A2:  coef_q.a[2] <= cfg_data;
				REG_A3:  coef_q.a[3] <= cfg_data;
				REG_A0:  coef_q.a0   <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	mciir_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.channel   (channel),
		.sample_in (sample_in),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	mciir_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel_out (channel_out),
		.sample_out  (sample_out),
		.saturated   (saturated)
	);

endmodule

`default_nettype wire

### design/mciir_front.sv
// front end: takes input requests, flags out-of-range channels, queues them
// depends on mciir_pkg
`default_nettype none

module mciir_front import mciir_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  chan_t   channel,
	input  sample_t sample_in,
	output logic    q_valid,
	output item_t   q_item,
	input  logic    q_pop
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;
	item_t             new_item;

	assign in_stall = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		new_item.chan     = channel;
		new_item.sample   = sample_in;
		new_item.in_range = (32'(channel) < CHANNELS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

`default_nettype wire

### design/mciir_back.sv
// back end: shared multiply-accumulate, serial divider, saturation,
// per-channel history and the output register; depends on mciir_pkg
`default_nettype none

module mciir_back import mciir_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  coef_t   coef,
	input  logic    q_valid,
	input  item_t   q_item,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_stall,
	output chan_t   channel_out,
	output sample_t sample_out,
	output logic    saturated
);

	back_state_t              state_q, state_d;
	item_t                    item_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     neg_q;
	logic                     zero_q;
	logic                     huge_q;
	logic [PART_W-1:0]        part_q;
	logic [QBITS-1:0]         quo_q;
	logic [ITER_W-1:0]        iter_q;
	logic                     out_valid_q;

	sample_t                  xh_q [CHANNELS][HDEPTH];
	sample_t                  yh_q [CHANNELS][HDEPTH];
	sample_t                  hx [HDEPTH];
	sample_t                  hy [HDEPTH];

	logic [STEP_W-1:0]        ff_k;
	logic [STEP_W-1:0]        fb_k;
	logic signed [15:0]       mul_c;
	logic signed [15:0]       mul_d;
	logic                     mul_sub;
	logic signed [31:0]       prod;

	logic [ACC_W-1:0]         mag_full;
	logic [MAG_W-1:0]         mag;
	logic [MAG_W-1:0]         limit;
	logic [PART_W-1:0]        trial;
	logic                     qbit;

	sample_t                  y_res;
	logic                     sat_res;
	logic                     load;
	logic                     out_free;

	assign out_free = !out_valid_q || !out_stall;

	// history of the current channel, zero for a channel out of range
	always_comb begin
		for (int k = 0; k < HDEPTH; k++) begin
			hx[k] = item_q.in_range ? xh_q[item_q.chan][k] : '0;
			hy[k] = item_q.in_range ? yh_q[item_q.chan][k] : '0;
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		ff_k    = step_q;
		fb_k    = step_q - STEP_W'(HIST);
		mul_c   = '0;
		mul_d   = '0;
		mul_sub = 1'b0;
		if (step_q == '0) begin
			mul_c = $signed(coef.b[0]);
			mul_d = item_q.sample;
		end else if (32'(step_q) <= HIST) begin
			mul_c = $signed(coef.b[ff_k[CIDX_W-1:0]]);
			mul_d = hx[HIDX_W'(ff_k - 1'b1)];
		end else begin
			mul_c   = $signed(coef.a[fb_k[CIDX_W-1:0]]);
			mul_d   = hy[HIDX_W'(fb_k - 1'b1)];
			mul_sub = 1'b1;
		end
		prod = mul_c * mul_d;
	end

	// divider setup and one restoring step
	always_comb begin
		mag_full = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		mag      = mag_full[MAG_W-1:0];
		limit    = MAG_W'(coef.a0) << QBITS;
		trial    = {part_q[PART_W-2:0], quo_q[QBITS-1]};
		qbit     = (trial >= PART_W'(coef.a0));
	end

	// sign, clipping and the flag
	always_comb begin
		y_res   = '0;
		sat_res = 1'b0;
		if (zero_q) begin
			y_res   = '0;
			sat_res = 1'b0;
		end else if (huge_q) begin
			y_res   = neg_q ? 16'sh8000 : 16'sh7fff;
			sat_res = 1'b1;
		end else if (!neg_q) begin
			if (quo_q > 16'h7fff) begin
				y_res   = 16'sh7fff;
				sat_res = 1'b1;
			end else begin
				y_res = $signed(quo_q);
			end
		end else begin
			if (quo_q > 16'h8000) begin
				y_res   = 16'sh8000;
				sat_res = 1'b1;
			end else begin
				y_res = $signed(-quo_q);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (step_q == STEP_W'(NSTEPS - 1)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = (mag >= limit) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (iter_q == ITER_W'(QBITS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  q_pop = q_valid;
			ST_DONE:  load  = out_free;
			default: begin
				q_pop = 1'b0;
				load  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				step_q <= '0;
			end
			ST_MAC: begin
				if (step_q == '0) begin
					acc_q <= ACC_W'(prod);
				end else if (mul_sub) begin
					acc_q <= acc_q - ACC_W'(prod);
				end else begin
					acc_q <= acc_q + ACC_W'(prod);
				end
				step_q <= step_q + 1'b1;
			end
			ST_SETUP: begin
				neg_q  <= acc_q[ACC_W-1];
				zero_q <= (acc_q == '0);
				huge_q <= (mag >= limit);
				part_q <= PART_W'(mag[MAG_W-1:QBITS]);
				quo_q  <= mag[QBITS-1:0];
				iter_q <= '0;
			end
			ST_DIV: begin
				part_q <= qbit ? trial - PART_W'(coef.a0) : trial;
				quo_q  <= {quo_q[QBITS-2:0], qbit};
				iter_q <= iter_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			channel_out <= item_q.chan;
			sample_out  <= y_res;
			saturated   <= sat_res;
		end
	end

	// per-channel delay lines, newest sample at slot zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < HDEPTH; k++) begin
					xh_q[c][k] <= '0;
					yh_q[c][k] <= '0;
				end
			end
		end else if (load && item_q.in_range && (HIST > 0)) begin
			xh_q[item_q.chan][0] <= item_q.sample;
			yh_q[item_q.chan][0] <= y_res;
			for (int k = 1; k < HDEPTH; k++) begin
				xh_q[item_q.chan][k] <= xh_q[item_q.chan][k-1];
				yh_q[item_q.chan][k] <= yh_q[item_q.chan][k-1];
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### design/mciir_checker.sv
// port-level checks of the multichannel iir filter, bound to the top level
// no dependencies beyond the top level's ports
`default_nettype none

module mciir_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        channel_out,
	input logic signed [15:0] sample_out,
	input logic              saturated
);

	// queue of two, one in the engine, one in the output register
	localparam logic [2:0] MAX_PENDING = 3'd4;

	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// a result is only shown for a request that came in
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result shown with no request outstanding");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MAX_PENDING)
		else $error("more requests in flight than the block can hold");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(sample_out == 16'sh7fff || sample_out == 16'sh8000))
		else $error("saturation flag with a value inside range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(sample_out) && $stable(channel_out)
				&& $stable(saturated)))
		else $error("stalled result changed");

endmodule

bind multichannel_iir_filter mciir_checker u_chk (.*);

`default_nettype wire
